// ----- sv/xmbr_pkg.sv -----
// Package for the XMODEM block receiver: phase, reply, verdict and status codes, shared types.
package xmbr_pkg;

    localparam int unsigned PAYLOAD_BYTES = 128;
    localparam int unsigned IDX_W         = 7;
    localparam int unsigned ADDR_W        = 15;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_CAN = 8'h18;

    localparam logic [7:0] LAST_INDEX = 8'(PAYLOAD_BYTES - 1);
    localparam logic [7:0] CMP_BASE   = 8'd255;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CMD,
        PH_BLK,
        PH_CMP,
        PH_DATA,
        PH_SUM
    } phase_t;

    typedef enum logic [1:0] {
        RP_ACK = 2'd0,
        RP_NAK = 2'd1,
        RP_CAN = 2'd2
    } reply_t;

    typedef enum logic [1:0] {
        VD_NONE   = 2'd0,
        VD_COMMIT = 2'd1,
        VD_DUP    = 2'd2,
        VD_REJECT = 2'd3
    } verdict_t;

    typedef enum logic [2:0] {
        ST_RUN     = 3'd0,
        ST_DONE    = 3'd1,
        ST_CANCEL  = 3'd2,
        ST_PROTO   = 3'd3,
        ST_TIMEOUT = 3'd4
    } status_t;

    typedef struct packed {
        phase_t           phase;
        logic [7:0]       expected_block;
        logic [7:0]       got_block;
        logic [7:0]       got_complement;
        logic [IDX_W-1:0] byte_index;
        logic [7:0]       running_sum;
        logic [7:0]       timeout_count;
    } ctx_t;

    typedef struct packed {
        logic              send_valid;
        reply_t            send_code;
        logic              data_valid;
        logic [ADDR_W-1:0] data_address;
        logic [7:0]        data_byte;
        verdict_t          block_verdict;
        status_t           transfer_status;
    } res_t;

endpackage

// ----- sv/xmbr_step.sv -----
// Per-item protocol step: next receiver state and the result item for one input item.
module xmbr_step (
    input  xmbr_pkg::ctx_t cur,
    input  logic [7:0]     retry_limit,
    input  logic [7:0]     rx_byte,
    input  logic           is_timeout,
    output xmbr_pkg::ctx_t nxt,
    output xmbr_pkg::res_t res
);

    logic [7:0] limit;
    logic [7:0] tcount_inc;
    logic [7:0] prev_block;
    logic       is_dup;
    logic       is_bad;
    logic       last_byte;

    assign limit      = (retry_limit == 8'd0) ? 8'd1 : retry_limit;
    assign tcount_inc = cur.timeout_count + 8'd1;
    assign prev_block = cur.expected_block - 8'd1;
    assign is_dup     = (cur.expected_block > 8'd1) && (cur.got_block == prev_block);
    assign is_bad     = (cur.got_block != cur.expected_block)
                     || (cur.got_complement != (xmbr_pkg::CMP_BASE - cur.got_block))
                     || (cur.running_sum != rx_byte);
    assign last_byte  = ({1'b0, cur.byte_index} >= xmbr_pkg::LAST_INDEX);

    // next state
    always_comb
    begin
        nxt = cur;
        case (cur.phase)
            xmbr_pkg::PH_CMD:
            begin
                if (is_timeout)
                begin
                    nxt.timeout_count = tcount_inc;
                    if (tcount_inc >= limit)
                    begin
                        nxt.phase = xmbr_pkg::PH_IDLE;
                    end
                end
                else if (rx_byte == xmbr_pkg::CH_SOH)
                begin
                    nxt.phase       = xmbr_pkg::PH_BLK;
                    nxt.byte_index  = '0;
                    nxt.running_sum = '0;
                end
                else
                begin
                    nxt.phase = xmbr_pkg::PH_IDLE;
                end
            end
            xmbr_pkg::PH_BLK, xmbr_pkg::PH_CMP, xmbr_pkg::PH_DATA, xmbr_pkg::PH_SUM:
            begin
                if (is_timeout)
                begin
                    nxt.phase         = xmbr_pkg::PH_CMD;
                    nxt.timeout_count = '0;
                end
                else if (cur.phase == xmbr_pkg::PH_BLK)
                begin
                    nxt.got_block = rx_byte;
                    nxt.phase     = xmbr_pkg::PH_CMP;
                end
                else if (cur.phase == xmbr_pkg::PH_CMP)
                begin
                    nxt.got_complement = rx_byte;
                    nxt.phase          = xmbr_pkg::PH_DATA;
                end
                else if (cur.phase == xmbr_pkg::PH_DATA)
                begin
                    nxt.running_sum = cur.running_sum + rx_byte;
                    if (last_byte)
                    begin
                        nxt.byte_index = '0;
                        nxt.phase      = xmbr_pkg::PH_SUM;
                    end
                    else
                    begin
                        nxt.byte_index = cur.byte_index + 1'b1;
                    end
                end
                else
                begin
                    if (!is_dup && !is_bad)
                    begin
                        nxt.expected_block = cur.expected_block + 8'd1;
                    end
                    nxt.phase         = xmbr_pkg::PH_CMD;
                    nxt.timeout_count = '0;
                end
            end
            default:
            begin
                nxt.phase = xmbr_pkg::PH_IDLE;
                if (!is_timeout && rx_byte == xmbr_pkg::CH_SOH)
                begin
                    nxt.expected_block = 8'd1;
                    nxt.timeout_count  = '0;
                    nxt.phase          = xmbr_pkg::PH_BLK;
                    nxt.byte_index     = '0;
                    nxt.running_sum    = '0;
                end
            end
        endcase
    end

    // result item
    always_comb
    begin
        res = '{send_valid: 1'b0, send_code: xmbr_pkg::RP_ACK, data_valid: 1'b0,
                data_address: '0, data_byte: '0, block_verdict: xmbr_pkg::VD_NONE,
                transfer_status: xmbr_pkg::ST_RUN};
        case (cur.phase)
            xmbr_pkg::PH_CMD:
            begin
                if (is_timeout)
                begin
                    res.send_valid = 1'b1;
                    res.send_code  = xmbr_pkg::RP_NAK;
                    if (tcount_inc >= limit)
                    begin
                        res.transfer_status = xmbr_pkg::ST_TIMEOUT;
                    end
                end
                else if (rx_byte == xmbr_pkg::CH_SOH)
                begin
                    res.send_valid = 1'b0;
                end
                else if (rx_byte == xmbr_pkg::CH_EOT)
                begin
                    res.send_valid      = 1'b1;
                    res.send_code       = xmbr_pkg::RP_ACK;
                    res.transfer_status = xmbr_pkg::ST_DONE;
                end
                else if (rx_byte == xmbr_pkg::CH_CAN)
                begin
                    res.transfer_status = xmbr_pkg::ST_CANCEL;
                end
                else
                begin
                    res.send_valid      = 1'b1;
                    res.send_code       = xmbr_pkg::RP_CAN;
                    res.transfer_status = xmbr_pkg::ST_PROTO;
                end
            end
            xmbr_pkg::PH_BLK, xmbr_pkg::PH_CMP, xmbr_pkg::PH_DATA, xmbr_pkg::PH_SUM:
            begin
                if (is_timeout)
                begin
                    res.send_valid    = 1'b1;
                    res.send_code     = xmbr_pkg::RP_NAK;
                    res.block_verdict = xmbr_pkg::VD_REJECT;
                end
                else if (cur.phase == xmbr_pkg::PH_DATA)
                begin
                    res.data_valid   = 1'b1;
                    res.data_byte    = rx_byte;
                    res.data_address = {prev_block, cur.byte_index};
                end
                else if (cur.phase == xmbr_pkg::PH_SUM)
                begin
                    res.send_valid = 1'b1;
                    if (is_dup)
                    begin
                        res.send_code     = xmbr_pkg::RP_ACK;
                        res.block_verdict = xmbr_pkg::VD_DUP;
                    end
                    else if (is_bad)
                    begin
                        res.send_code     = xmbr_pkg::RP_NAK;
                        res.block_verdict = xmbr_pkg::VD_REJECT;
                    end
                    else
                    begin
                        res.send_code     = xmbr_pkg::RP_ACK;
                        res.block_verdict = xmbr_pkg::VD_COMMIT;
                    end
                end
            end
            default:
            begin
                res.send_valid = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/xmodem_block_receiver.sv -----
// Top level of the XMODEM checksum block receiver: state, config and result registers.
// One item is one received byte or one read timeout, and each item gives exactly one
// result item. An accepted item updates the protocol state register and loads its result
// into the output register at the same clock edge; a new item is taken every cycle
// as long as the output register is empty or is being drained, so the sustained rate is
// one item per clock, set by the single compare-and-add step per byte. retry_limit is
// written through cfg_we/cfg_data and resets to 10; a value of 0 acts as 1.
module xmodem_block_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        is_timeout,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        send_valid,
    output logic [1:0]  send_code,
    output logic        data_valid,
    output logic [14:0] data_address,
    output logic [7:0]  data_byte,
    output logic [1:0]  block_verdict,
    output logic [2:0]  transfer_status
);

    xmbr_pkg::ctx_t ctx_reg;
    xmbr_pkg::ctx_t ctx_next;
    xmbr_pkg::res_t res_reg;
    xmbr_pkg::res_t res_next;
    logic [7:0]     retry_limit_reg;
    logic           out_valid_reg;
    logic           in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    xmbr_step u_step (
        .cur         (ctx_reg),
        .retry_limit (retry_limit_reg),
        .rx_byte     (rx_byte),
        .is_timeout  (is_timeout),
        .nxt         (ctx_next),
        .res         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg         <= '{phase: xmbr_pkg::PH_IDLE, expected_block: 8'd1,
                                 got_block: '0, got_complement: '0, byte_index: '0,
                                 running_sum: '0, timeout_count: '0};
            retry_limit_reg <= 8'd10;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                retry_limit_reg <= cfg_data;
            end
            if (in_fire)
            begin
                ctx_reg <= ctx_next;
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign send_valid      = res_reg.send_valid;
    assign send_code       = res_reg.send_code;
    assign data_valid      = res_reg.data_valid;
    assign data_address    = res_reg.data_address;
    assign data_byte       = res_reg.data_byte;
    assign block_verdict   = res_reg.block_verdict;
    assign transfer_status = res_reg.transfer_status;

`ifndef ASSERT_OFF
    a_data_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.data_valid) |->
            (!res_reg.send_valid && res_reg.block_verdict == xmbr_pkg::VD_NONE))
        else $error("payload item carries a reply or verdict");

    a_commit_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && res_next.block_verdict == xmbr_pkg::VD_COMMIT) |=>
            (ctx_reg.expected_block == $past(ctx_reg.expected_block) + 8'd1))
        else $error("commit did not advance expected block");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(res_reg)))
        else $error("stalled result changed");

    a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && res_next.transfer_status != xmbr_pkg::ST_RUN) |=>
            (ctx_reg.phase == xmbr_pkg::PH_IDLE))
        else $error("transfer ended but phase not idle");
`endif

endmodule
